// ----- hdl/lbf_pkg.sv -----
`default_nettype none

package lbf_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 4096;
  localparam int unsigned CHUNK_BYTES_DEF  = 14;
  localparam int unsigned FRAME_WORDS_DEF  = 8;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SRC_W     = 13;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned CHUNK_W   = 4;
  localparam int unsigned WIDX_W    = 3;
  localparam int unsigned BADDR_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_WORD  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MAX_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COMMAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_COMMAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_ID       = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] block_max_size;
    logic [SRC_W-1:0]  source_size;
    logic [WORD_W-1:0] init_command;
    logic [WORD_W-1:0] content_command;
    logic [WORD_W-1:0] player_id;
  } lbf_cfg_t;

  // Everything about one result word except the buffer bytes.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              use_mem;
    logic              lo_ok;
    logic              hi_ok;
    logic              last;
    logic              done;
  } lbf_meta_t;

endpackage

`default_nettype wire

// ----- hdl/lbf_ifs.sv -----
`default_nettype none

interface lbf_req_if import lbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [BADDR_W-1:0] byte_address;
  logic [7:0]         byte_value;

  modport source (output valid, output req_type, output byte_address, output byte_value,
                  input ready);
  modport sink (input valid, input req_type, input byte_address, input byte_value,
                output ready);
endinterface

interface lbf_rsp_if import lbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] link_word;
  logic              frame_last;
  logic              block_done;

  modport source (output valid, output link_word, output frame_last, output block_done,
                  input ready);
  modport sink (input valid, input link_word, input frame_last, input block_done,
                output ready);
endinterface

interface lbf_cfg_if import lbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lbf_cfg_regs.sv -----
`default_nettype none

module lbf_cfg_regs import lbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  lbf_cfg_if.sink   cfg,
  output lbf_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BLOCK_MAX_SIZE:  regs.block_max_size  <= cfg.data;
        CFG_SOURCE_SIZE:     regs.source_size     <= cfg.data[SRC_W-1:0];
        CFG_INIT_COMMAND:    regs.init_command    <= cfg.data;
        CFG_CONTENT_COMMAND: regs.content_command <= cfg.data;
        CFG_PLAYER_ID:       regs.player_id       <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lbf_src_buf.sv -----
`default_nettype none

module lbf_src_buf #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr0,
  input  wire logic [AW-1:0] rd_addr1,
  output logic      [7:0]    rd_data0,
  output logic      [7:0]    rd_data1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no new word is read, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lbf_framer.sv -----
`default_nettype none

module lbf_framer import lbf_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int unsigned CHUNK_BYTES  = CHUNK_BYTES_DEF,
  parameter int unsigned FRAME_WORDS  = FRAME_WORDS_DEF,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    req_type,
  input  wire lbf_cfg_t      regs,
  output logic               rd_en,
  output logic      [AW-1:0] rd_addr0,
  output logic      [AW-1:0] rd_addr1,
  output logic               meta_valid,
  output lbf_meta_t          meta
);

  logic [WIDX_W-1:0]  word_index, word_index_next;
  logic               header_sent, header_sent_next;
  logic [POS_W-1:0]   read_position, read_position_next;
  logic [SRC_W-1:0]   source_left, source_left_next;
  logic [SIZE_W-1:0]  size_left, size_left_next;
  logic [CHUNK_W-1:0] chunk_valid, chunk_valid_next;
  logic               done_flag, done_flag_next;

  logic [WIDX_W-1:0]  widx_m1;
  logic [CHUNK_W-1:0] offset;
  logic [CHUNK_W:0]   offset_hi;
  logic [POS_W:0]     pos_sum;
  logic               last;
  logic [SRC_W-1:0]   src_clamp;
  logic [CHUNK_W-1:0] take_cv;
  logic [SIZE_W-1:0]  size_dec;

  always_comb begin
    widx_m1   = word_index - 1'b1;
    offset    = {widx_m1, 1'b0};
    offset_hi = {1'b0, offset} + 1'b1;
    pos_sum   = {1'b0, read_position} + (POS_W+1)'(offset);
    rd_addr0  = AW'(pos_sum);
    rd_addr1  = AW'((POS_W+1)'(pos_sum + 1'b1));
    last      = ({1'b0, word_index} + 1'b1) >= (WIDX_W+1)'(FRAME_WORDS);
    src_clamp = (32'(regs.source_size) > BUFFER_DEPTH) ? SRC_W'(BUFFER_DEPTH)
                                                       : regs.source_size;
    take_cv   = (32'(source_left) < CHUNK_BYTES) ? CHUNK_W'(source_left)
                                                 : CHUNK_W'(CHUNK_BYTES);
    size_dec  = (32'(size_left) < CHUNK_BYTES) ? size_left : SIZE_W'(CHUNK_BYTES);

    word_index_next    = word_index;
    header_sent_next   = header_sent;
    read_position_next = read_position;
    source_left_next   = source_left;
    size_left_next     = size_left;
    chunk_valid_next   = chunk_valid;
    done_flag_next     = done_flag;
    rd_en              = 1'b0;
    meta_valid         = 1'b0;
    meta               = '0;

    if (accept) begin
      case (req_type)
        REQ_START: begin
          source_left_next   = src_clamp;
          size_left_next     = regs.block_max_size;
          word_index_next    = '0;
          header_sent_next   = 1'b0;
          read_position_next = '0;
          chunk_valid_next   = '0;
          done_flag_next     = (regs.block_max_size == '0);
        end
        REQ_WORD: begin
          meta_valid = 1'b1;
          if (!header_sent) begin
            if (word_index == WIDX_W'(0)) begin
              meta.word = regs.init_command;
            end else if (word_index == WIDX_W'(1)) begin
              meta.word = size_left;
            end else if (word_index == WIDX_W'(2)) begin
              meta.word = regs.player_id;
            end
          end else if (word_index == '0) begin
            // First word of a content frame takes the next chunk.
            read_position_next = read_position + POS_W'(chunk_valid);
            if (size_left != '0) begin
              chunk_valid_next = take_cv;
              source_left_next = source_left - SRC_W'(take_cv);
              size_left_next   = size_left - size_dec;
            end else begin
              chunk_valid_next = '0;
            end
            done_flag_next = (size_left_next == '0);
            meta.word      = regs.content_command;
          end else begin
            rd_en        = 1'b1;
            meta.use_mem = 1'b1;
            meta.lo_ok   = offset < chunk_valid;
            meta.hi_ok   = offset_hi < {1'b0, chunk_valid};
          end
          meta.last = last;
          meta.done = done_flag_next;
          if (last) begin
            word_index_next  = '0;
            header_sent_next = 1'b1;
          end else begin
            word_index_next = word_index + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index    <= '0;
      header_sent   <= 1'b0;
      read_position <= '0;
      source_left   <= '0;
      size_left     <= '0;
      chunk_valid   <= '0;
      done_flag     <= 1'b0;
    end else begin
      word_index    <= word_index_next;
      header_sent   <= header_sent_next;
      read_position <= read_position_next;
      source_left   <= source_left_next;
      size_left     <= size_left_next;
      chunk_valid   <= chunk_valid_next;
      done_flag     <= done_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lbf_out_stage.sv -----
`default_nettype none

module lbf_out_stage import lbf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       meta_valid,
  input  wire lbf_meta_t  meta,
  input  wire logic [7:0] rd_data0,
  input  wire logic [7:0] rd_data1,
  output logic            take,
  lbf_rsp_if.source       rsp
);

  logic      s1_valid;
  lbf_meta_t s1_meta;
  logic      out_free;
  logic      s1_move;
  logic [WORD_W-1:0] word;

  assign out_free = !rsp.valid || rsp.ready;
  assign s1_move  = s1_valid && out_free;
  assign take     = !s1_valid || out_free;

  always_comb begin
    if (s1_meta.use_mem) begin
      word = {s1_meta.hi_ok ? rd_data1 : 8'h00, s1_meta.lo_ok ? rd_data0 : 8'h00};
    end else begin
      word = s1_meta.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= meta_valid;
      end
      if (out_free) begin
        rsp.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_meta <= meta;
    end
    if (s1_move) begin
      rsp.link_word  <= word;
      rsp.frame_last <= s1_meta.last;
      rsp.block_done <= s1_meta.done;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/link_block_framer.sv -----
// A word request's result is registered in the s1 stage and then in the output register.
// Throughput: one item per cycle while the output is not stalled; load and start items give no result.
// The two buffer bytes of a content word come from one dual-read buffer access.
// Reset (synchronous, active high) clears the config registers, framing counters
// and valid flags; the source buffer keeps its contents, undefined until loaded.
`default_nettype none

module link_block_framer import lbf_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int unsigned CHUNK_BYTES  = CHUNK_BYTES_DEF,
  parameter int unsigned FRAME_WORDS  = FRAME_WORDS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  lbf_req_if.sink   req,
  lbf_rsp_if.source rsp,
  lbf_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  lbf_cfg_t  regs;
  lbf_meta_t meta;
  logic      meta_valid;
  logic      take;
  logic      accept;
  logic      rd_en;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  logic [7:0]    rd_data0;
  logic [7:0]    rd_data1;

  assign req.ready = take;
  assign accept    = req.valid && req.ready;

  lbf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lbf_src_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_src_buf (
    .clk      (clk),
    .wr_en    (accept && (req.req_type == REQ_LOAD)),
    .wr_addr  (AW'(req.byte_address)),
    .wr_data  (req.byte_value),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  lbf_framer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CHUNK_BYTES  (CHUNK_BYTES),
    .FRAME_WORDS  (FRAME_WORDS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req.req_type),
    .regs       (regs),
    .rd_en      (rd_en),
    .rd_addr0   (rd_addr0),
    .rd_addr1   (rd_addr1),
    .meta_valid (meta_valid),
    .meta       (meta)
  );

  lbf_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .meta_valid (meta_valid),
    .meta       (meta),
    .rd_data0   (rd_data0),
    .rd_data1   (rd_data1),
    .take       (take),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// ----- hdl/lbf_checker.sv -----
`default_nettype none

module lbf_checker import lbf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_ready,
  input wire logic [1:0]        req_type,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [WORD_W-1:0] link_word,
  input wire logic              frame_last,
  input wire logic              block_done
);

  // A stalled result keeps its content.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({link_word, frame_last, block_done}))
    else $error("result changed while stalled");

  // With the output empty, the pipeline behind it always drains, so items are taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled with an empty output");

  // A result that appears on an empty output came from a word request that passed through the s1 stage.
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_type == REQ_WORD), 2))
    else $error("result without a word request");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind link_block_framer lbf_checker u_lbf_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .link_word  (rsp.link_word),
  .frame_last (rsp.frame_last),
  .block_done (rsp.block_done)
);

`default_nettype wire
